[rtl/mvm_pkg.sv]
// ---------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the matrix-vector multiply-accumulate block.
// ---------------------------------------------------------------------------
package mvm_pkg;

  localparam int MAX_LEN_DEF    = 1024;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int ACC_W      = 48;
  localparam int ROW_W      = 16;
  localparam int ROWS_W     = 17;
  localparam int VLEN_W     = 11;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int ROWS_MAX   = 65536;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_VEC  = 2'd0,
    KIND_SEED = 2'd1,
    KIND_MAC  = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_VEC_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_CNT = 1'b1;

  typedef struct packed {
    logic             is_seed;
    logic             end_row;
    logic             last_row;
    logic [ROW_W-1:0] row_index;
  } op_ctrl_t;

endpackage

[rtl/mvm_if.sv]
// ---------------------------------------------------------------------------
// mvm_if
// Valid/ready channels: input words and result words.
// ---------------------------------------------------------------------------
interface mvm_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [DATA_WIDTH-1:0] value;
  logic [47:0]           seed;

  modport source (output valid, kind, value, seed, input ready);
  modport sink   (input valid, kind, value, seed, output ready);
endinterface

interface mvm_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] row_sum;
  logic [15:0] row_index;
  logic        last_row;

  modport source (output valid, row_sum, row_index, last_row, input ready);
  modport sink   (input valid, row_sum, row_index, last_row, output ready);
endinterface

[rtl/mvm_front.sv]
// ---------------------------------------------------------------------------
// mvm_front
// Accepts input words, holds configuration, vector store and indices, and
// issues seed and multiply operations with their vector operand.
// ---------------------------------------------------------------------------
module mvm_front import mvm_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int OPD_W      = ACC_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mvm_in_if.sink               in_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 push,
  output op_ctrl_t             push_ctrl,
  output logic [OPD_W-1:0]     push_data,
  input  logic                 q_ready
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [VLEN_W-1:0]     vec_len_r;
  logic [ROWS_W-1:0]     row_cnt_r;
  logic [LEN_W-1:0]      ld_idx_r;
  logic [LEN_W-1:0]      col_idx_r;
  logic [ROW_W-1:0]      row_r;
  logic                  f1_valid_r;
  op_ctrl_t              f1_ctrl_r;
  logic [DATA_WIDTH-1:0] f1_value_r;
  logic [ACC_W-1:0]      f1_seed_r;
  logic [DATA_WIDTH-1:0] mem_rd_r;
  logic [DATA_WIDTH-1:0] vec_mem [MAX_LEN];

  logic [LEN_W-1:0]      eff_len;
  logic [ROWS_W-1:0]     eff_rows;
  logic [LEN_W:0]        ld_inc;
  logic [LEN_W:0]        col_inc;
  logic [ROWS_W-1:0]     row_inc;
  logic                  ld_wrap;
  logic                  col_end;
  logic                  row_last;
  logic                  accept;
  logic                  is_vec;
  logic                  is_seed;
  logic                  is_mac;

  always_comb begin
    if (vec_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(vec_len_r) > 32'(MAX_LEN)) begin
      eff_len = LEN_W'(MAX_LEN);
    end else begin
      eff_len = LEN_W'(vec_len_r);
    end
    if (row_cnt_r == '0) begin
      eff_rows = ROWS_W'(1);
    end else if (32'(row_cnt_r) > 32'(ROWS_MAX)) begin
      eff_rows = ROWS_W'(ROWS_MAX);
    end else begin
      eff_rows = row_cnt_r;
    end
  end

  assign ld_inc   = {1'b0, ld_idx_r} + (LEN_W + 1)'(1);
  assign col_inc  = {1'b0, col_idx_r} + (LEN_W + 1)'(1);
  assign row_inc  = {1'b0, row_r} + ROWS_W'(1);
  assign ld_wrap  = ld_inc >= {1'b0, eff_len};
  assign col_end  = col_inc >= {1'b0, eff_len};
  assign row_last = row_inc >= eff_rows;

  assign in_ch.ready = !f1_valid_r || q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_vec      = in_ch.kind == KIND_VEC;
  assign is_seed     = in_ch.kind == KIND_SEED;
  assign is_mac      = in_ch.kind == KIND_MAC;

  assign push      = f1_valid_r && q_ready;
  assign push_ctrl = f1_ctrl_r;

  always_comb begin
    push_data = '0;
    if (f1_ctrl_r.is_seed) begin
      push_data[ACC_W-1:0] = f1_seed_r;
    end else begin
      push_data[2*DATA_WIDTH-1:0] = {f1_value_r, mem_rd_r};
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_len_r <= VLEN_W'(1);
      row_cnt_r <= ROWS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VEC_LEN: vec_len_r <= cfg_data[VLEN_W-1:0];
        REG_ROW_CNT: row_cnt_r <= cfg_data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // indices and issue stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_idx_r   <= '0;
      col_idx_r  <= '0;
      row_r      <= '0;
      f1_valid_r <= 1'b0;
    end else if (accept) begin
      f1_valid_r <= is_seed || is_mac;
      if (is_vec) begin
        ld_idx_r <= ld_wrap ? '0 : ld_inc[LEN_W-1:0];
      end
      if (is_mac) begin
        if (col_end) begin
          col_idx_r <= '0;
          row_r     <= row_last ? '0 : row_inc[ROW_W-1:0];
        end else begin
          col_idx_r <= col_inc[LEN_W-1:0];
        end
      end
    end else if (push) begin
      f1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_ctrl_r.is_seed   <= is_seed;
      f1_ctrl_r.end_row   <= col_end;
      f1_ctrl_r.last_row  <= row_last;
      f1_ctrl_r.row_index <= row_r;
      f1_value_r          <= in_ch.value;
      f1_seed_r           <= in_ch.seed;
    end
  end

  // vector store, read data registered
  always_ff @(posedge clk) begin
    if (accept && is_vec) begin
      vec_mem[ld_idx_r[ADDR_W-1:0]] <= in_ch.value;
    end
    if (accept && is_mac) begin
      mem_rd_r <= vec_mem[col_idx_r[ADDR_W-1:0]];
    end
  end

endmodule

[rtl/mvm_queue.sv]
// ---------------------------------------------------------------------------
// mvm_queue
// Short FIFO of issued operations between front and back.
// ---------------------------------------------------------------------------
module mvm_queue import mvm_pkg::*; #(
  parameter int OPD_W = ACC_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  op_ctrl_t         push_ctrl,
  input  logic [OPD_W-1:0] push_data,
  output logic             q_ready,
  input  logic             pop,
  output logic             q_valid,
  output op_ctrl_t         pop_ctrl,
  output logic [OPD_W-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_ctrl_t         ctrl_mem [QUEUE_DEPTH];
  logic [OPD_W-1:0] data_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_pop;

  assign q_ready  = cnt_r != CNT_W'(QUEUE_DEPTH);
  assign q_valid  = cnt_r != '0;
  assign do_pop   = pop && q_valid;
  assign pop_ctrl = ctrl_mem[rd_ptr_r];
  assign pop_data = data_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_mem[wr_ptr_r] <= push_ctrl;
      data_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/mvm_back.sv]
// ---------------------------------------------------------------------------
// mvm_back
// Multiplies, accumulates into the 48-bit row sum and drives result words.
// ---------------------------------------------------------------------------
module mvm_back import mvm_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int OPD_W      = ACC_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  op_ctrl_t         pop_ctrl,
  input  logic [OPD_W-1:0] pop_data,
  output logic             pop,
  mvm_out_if.source        out_ch
);

  localparam int PROD_W = 2 * DATA_WIDTH;

  logic                     b_en;
  logic                     b1_valid_r;
  op_ctrl_t                 b1_ctrl_r;
  logic signed [PROD_W-1:0] b1_prod_r;
  logic [ACC_W-1:0]         b1_seed_r;
  logic [ACC_W-1:0]         acc_r;
  logic                     out_valid_r;
  logic [ACC_W-1:0]         out_sum_r;
  logic [ROW_W-1:0]         out_row_r;
  logic                     out_last_r;

  logic signed [DATA_WIDTH-1:0] op_a;
  logic signed [DATA_WIDTH-1:0] op_b;
  logic [ACC_W-1:0]             prod_ext;
  logic [ACC_W-1:0]             sum;
  logic                         emit;

  assign b_en     = !out_valid_r || out_ch.ready;
  assign pop      = b_en && q_valid;
  assign op_a     = pop_data[PROD_W-1:DATA_WIDTH];
  assign op_b     = pop_data[DATA_WIDTH-1:0];
  assign prod_ext = ACC_W'(b1_prod_r);
  assign sum      = acc_r + prod_ext;
  assign emit     = b1_valid_r && !b1_ctrl_r.is_seed && b1_ctrl_r.end_row;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_sum   = out_sum_r;
  assign out_ch.row_index = out_row_r;
  assign out_ch.last_row  = out_last_r;

  // stage 1: product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (b_en) begin
      b1_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_ctrl_r <= pop_ctrl;
      b1_prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
      b1_seed_r <= pop_data[ACC_W-1:0];
    end
  end

  // stage 2: accumulate, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (b_en) begin
      out_valid_r <= emit;
      if (b1_valid_r) begin
        if (b1_ctrl_r.is_seed) begin
          acc_r <= b1_seed_r;
        end else if (b1_ctrl_r.end_row) begin
          acc_r <= '0;
        end else begin
          acc_r <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_en && emit) begin
      out_sum_r  <= sum;
      out_row_r  <= b1_ctrl_r.row_index;
      out_last_r <= b1_ctrl_r.last_row;
    end
  end

endmodule

[rtl/matrix_vector_mac_top.sv]
// ---------------------------------------------------------------------------
// matrix_vector_mac_top
// Matrix-vector multiply-accumulate with streamed vector and 48-bit rows.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind, value, seed
//   out_ch   out  valid/ready    row_sum, row_index, last_row
//   cfg_*    in   cfg_we only    cfg_index, cfg_data
//
// One input word per cycle while the queue has room, set by the single-port
// vector store read and the one multiplier in the back end. Once its last
// matrix word is taken, a row sum passes the issue, queue, product and result
// registers. Reset is synchronous; no clearing pass. A stalled result holds
// the back end; the 4-entry queue keeps the input side open until it fills.
// ---------------------------------------------------------------------------
module matrix_vector_mac_top import mvm_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mvm_in_if.sink               in_ch,
  mvm_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int OPD_W = (2 * DATA_WIDTH > ACC_W) ? 2 * DATA_WIDTH : ACC_W;

  logic             push;
  op_ctrl_t         push_ctrl;
  logic [OPD_W-1:0] push_data;
  logic             q_ready;
  logic             pop;
  logic             q_valid;
  op_ctrl_t         pop_ctrl;
  logic [OPD_W-1:0] pop_data;

  mvm_front #(
    .MAX_LEN    (MAX_LEN),
    .DATA_WIDTH (DATA_WIDTH),
    .OPD_W      (OPD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_ctrl (push_ctrl),
    .push_data (push_data),
    .q_ready   (q_ready)
  );

  mvm_queue #(
    .OPD_W (OPD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ctrl (push_ctrl),
    .push_data (push_data),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_ctrl  (pop_ctrl),
    .pop_data  (pop_data)
  );

  mvm_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .OPD_W      (OPD_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .pop_ctrl (pop_ctrl),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

[rtl/mvm_checker.sv]
// ---------------------------------------------------------------------------
// mvm_checker
// Port-level checks on reset behaviour and the result channel.
// ---------------------------------------------------------------------------
module mvm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_row_sum,
  input logic [15:0] out_row_index,
  input logic        out_last_row
);

  a_rst_no_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_row_sum) && $stable(out_row_index)
      && $stable(out_last_row))
    else $error("result word changed while stalled");

endmodule

bind matrix_vector_mac_top mvm_checker u_mvm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_row_sum   (out_ch.row_sum),
  .out_row_index (out_ch.row_index),
  .out_last_row  (out_ch.last_row)
);

[dv/tb_matrix_vector_mac_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matrix_vector_mac_top
// Self-checking bench for the matrix-vector multiply-accumulate block. Vector,
// seed and matrix words go in over the input channel; a local model of the
// store, the row position and the 48-bit accumulator predicts every row sum,
// which is compared field by field with what comes out. Directed cases cover
// operand and seed extremes, zero and oversized shapes, mid-row shrinking and
// long 64-column rows; random phases mix rows, noise and reshaping under
// several flow-control mixes, and a long output hold-off stalls the results.
// ---------------------------------------------------------------------------
module tb_matrix_vector_mac_top;
  import mvm_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam longint CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 180;

  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic [ROW_W-1:0] index;
    logic             last;
  } row_sum_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mvm_in_if #(.DATA_WIDTH(DATA_WIDTH_DEF)) in_ch ();
  mvm_out_if out_ch ();

  matrix_vector_mac_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the block's state
  logic signed [15:0] vec_mem [MAX_LEN_DEF];
  bit               vec_written [MAX_LEN_DEF];
  int               load_idx = 0;
  int               col_idx = 0;
  int               row_ctr = 0;
  logic [ACC_W-1:0] acc = '0;
  logic [VLEN_W-1:0] vlen_reg = 11'd1;
  logic [ROWS_W-1:0] rows_reg = 17'd1;

  row_sum_t         row_sums_due [$];

  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_request = 0;
  int unsigned      hold_left = 0;
  int unsigned      words_sent = 0;
  int unsigned      sums_checked = 0;
  int unsigned      err_count = 0;
  longint           cycle_count = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int active_len();
    if (vlen_reg == 0) return 1;
    if (vlen_reg > MAX_LEN_DEF) return MAX_LEN_DEF;
    return int'(vlen_reg);
  endfunction

  function automatic int active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > ROWS_MAX) return ROWS_MAX;
    return int'(rows_reg);
  endfunction

  task automatic step_dot_products(logic [1:0] k, logic [15:0] v, logic [47:0] s);
    int len;
    int rows;
    logic signed [31:0] prod;
    row_sum_t r;
    len = active_len();
    rows = active_rows();
    case (k)
      KIND_VEC: begin
        vec_mem[load_idx] = v;
        vec_written[load_idx] = 1'b1;
        load_idx = (load_idx + 1 >= len) ? 0 : load_idx + 1;
      end
      KIND_SEED: acc = s;
      KIND_MAC: begin
        prod = 32'($signed(v)) * 32'(vec_mem[col_idx]);
        acc = acc + {{16{prod[31]}}, prod};
        if (col_idx + 1 >= len) begin
          r.sum = acc;
          r.index = row_ctr[15:0];
          r.last = (row_ctr + 1 >= rows);
          row_sums_due.push_back(r);
          acc = '0;
          col_idx = 0;
          row_ctr = r.last ? 0 : row_ctr + 1;
        end else begin
          col_idx++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // one word over the input channel, with random gaps beforehand
  task automatic send_word(logic [1:0] k, logic [15:0] v, logic [47:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.value <= v;
    in_ch.seed  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    step_dot_products(k, v, s);
    if (k != KIND_NONE) words_sent++;
  endtask

  task automatic wait_for_sums();
    in_ch.valid <= 1'b0;
    while (row_sums_due.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_for_sums();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_shape(logic [VLEN_W-1:0] len, logic [ROWS_W-1:0] rows);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_VEC_LEN;
    cfg_data  <= {{(CFG_W-VLEN_W){1'b0}}, len};
    @(posedge clk);
    vlen_reg = len;
    cfg_index <= REG_ROW_CNT;
    cfg_data  <= rows;
    @(posedge clk);
    rows_reg = rows;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] pick_seed();
    case ($urandom_range(5))
      0: return 48'h8000_0000_0000;
      1: return 48'h7fff_ffff_ffff;
      2: return 48'h0;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [VLEN_W-1:0] pick_len();
    case ($urandom_range(9))
      0: return 11'd0;
      1: return 11'($urandom_range(9, 48));
      default: return 11'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [ROWS_W-1:0] pick_rows();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'd131071;
      3: return 17'($urandom_range(7, 40));
      default: return 17'($urandom_range(1, 6));
    endcase
  endfunction

  // realign the load pointer, then fill every column of the current length
  task automatic load_vector();
    while (load_idx != 0) send_word(KIND_VEC, pick_value(), pick_seed());
    repeat (active_len()) send_word(KIND_VEC, pick_value(), pick_seed());
  endtask

  task automatic send_row();
    int cols;
    cols = (col_idx >= active_len()) ? 1 : active_len() - col_idx;
    if ($urandom_range(3) != 0) send_word(KIND_SEED, pick_value(), pick_seed());
    repeat (cols) begin
      if ($urandom_range(19) == 0) send_word(KIND_NONE, pick_value(), pick_seed());
      send_word(KIND_MAC, pick_value(), pick_seed());
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_word(KIND_VEC, pick_value(), pick_seed());
      1: send_word(KIND_SEED, pick_value(), pick_seed());
      2: begin
        if (vec_written[col_idx]) send_word(KIND_MAC, pick_value(), pick_seed());
        else send_word(KIND_VEC, pick_value(), pick_seed());
      end
      default: send_word(KIND_NONE, pick_value(), pick_seed());
    endcase
  endtask

  // ---- tests ----

  task automatic test_reset_shape();
    send_word(KIND_VEC, 16'h7fff, 48'h0);
    send_word(KIND_MAC, 16'h7fff, 48'h0);
    send_word(KIND_SEED, 16'h0, 48'h7fff_ffff_ffff);
    send_word(KIND_MAC, 16'h7fff, 48'hffff_ffff_ffff);
  endtask

  task automatic test_extremes();
    set_shape(11'd3, 17'd2);
    send_word(KIND_VEC, 16'h8000, 48'h0);
    send_word(KIND_VEC, 16'h7fff, 48'hffff_ffff_ffff);
    send_word(KIND_VEC, 16'hffff, 48'h0);
    send_word(KIND_SEED, 16'hffff, 48'h8000_0000_0000);
    send_word(KIND_MAC, 16'h8000, 48'h0);
    send_word(KIND_MAC, 16'h7fff, 48'h0);
    send_word(KIND_MAC, 16'hffff, 48'h0);
    // unused kind and a seed landing mid-row
    send_word(KIND_MAC, 16'h7fff, 48'h0);
    send_word(KIND_NONE, 16'hffff, 48'hffff_ffff_ffff);
    send_word(KIND_MAC, 16'h8000, 48'h0);
    send_word(KIND_SEED, 16'h0, 48'h7fff_ffff_ffff);
    send_word(KIND_MAC, 16'h8000, 48'h0);
  endtask

  task automatic test_zero_shape();
    set_shape(11'd0, 17'd0);
    send_word(KIND_VEC, 16'h8000, 48'h0);
    send_word(KIND_MAC, 16'h8000, 48'h0);
    send_word(KIND_MAC, 16'h0001, 48'h0);
  endtask

  task automatic test_mid_row_shrink();
    set_shape(11'd6, 17'd4);
    load_vector();
    repeat (6) send_word(KIND_MAC, pick_value(), 48'h0);
    repeat (4) send_word(KIND_MAC, pick_value(), 48'h0);
    // column and row both past the new limits: next word closes the last row
    set_shape(11'd2, 17'd1);
    send_word(KIND_MAC, 16'h7fff, 48'h0);
    send_word(KIND_MAC, 16'h8000, 48'h0);
    send_word(KIND_MAC, 16'h0001, 48'h0);
  endtask

  task automatic test_long_row();
    set_shape(11'd64, 17'd65536);
    load_vector();
    send_row();
    set_shape(11'd64, 17'd131071);
    send_row();
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_shape(11'd1, 17'd7);
    load_vector();
    hold_request = 300;
    repeat (60) send_row();
    wait_for_sums();
    repeat (20) send_row();
  endtask

  task automatic test_random_mix(int unsigned idle, int unsigned stall);
    int unsigned start;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    start = words_sent;
    set_shape(pick_len(), pick_rows());
    load_vector();
    while (words_sent - start < PHASE_WORDS) begin
      if ($urandom_range(39) == 0) begin
        set_shape(pick_len(), pick_rows());
        load_vector();
      end
      if ($urandom_range(6) != 0) send_row();
      else send_noise();
    end
  endtask

  // ---- result side ----

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_rows
    row_sum_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (row_sums_due.size() == 0) begin
        report_mismatch("row sum with none due", 64'(out_ch.row_sum), 64'h0);
      end else begin
        want = row_sums_due.pop_front();
        sums_checked++;
        if (out_ch.row_sum !== want.sum)
          report_mismatch("row_sum", 64'(out_ch.row_sum), 64'(want.sum));
        if (out_ch.row_index !== want.index)
          report_mismatch("row_index", 64'(out_ch.row_index), 64'(want.index));
        if (out_ch.last_row !== want.last)
          report_mismatch("last_row", 64'(out_ch.last_row), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d row sums outstanding",
               cycle_count, row_sums_due.size());
      $display("tb_matrix_vector_mac_top: done, errors");
      $finish;
    end
  end

  initial begin
    int waited;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_VEC;
    in_ch.value <= '0;
    in_ch.seed  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_VEC_LEN;
    cfg_data    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_shape();
    test_extremes();
    test_zero_shape();
    test_mid_row_shrink();
    test_long_row();
    test_output_hold();
    test_random_mix(0, 0);
    test_random_mix(49, 0);
    test_random_mix(0, 49);
    test_random_mix(31, 31);

    in_ch.valid <= 1'b0;
    waited = 0;
    while (row_sums_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (row_sums_due.size() != 0) begin
      report_mismatch("row sum never arrived", 64'h0, 64'(row_sums_due[0].sum));
      void'(row_sums_due.pop_front());
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d words sent, %0d row sums checked, %0d mismatches",
             words_sent, sums_checked, err_count);
    $display("covered operand and seed extremes, 1 to 64 columns, up to 65536 rows,",
             " mid-row reshaping, four flow-control mixes and a long output hold");
    if (err_count == 0) begin
      $display("tb_matrix_vector_mac_top: done, clean");
    end else begin
      $display("tb_matrix_vector_mac_top: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mvm_pkg.sv
rtl/mvm_if.sv
rtl/mvm_front.sv
rtl/mvm_queue.sv
rtl/mvm_back.sv
rtl/matrix_vector_mac_top.sv
rtl/mvm_checker.sv
dv/tb_matrix_vector_mac_top.sv
